// ----- rtl/triggered_scope_capture_assert.svh -----
// Assertion macros shared by the capture block. Each expects i_clk and i_rst_n in scope.
`ifndef TRIGGERED_SCOPE_CAPTURE_ASSERT_SVH
`define TRIGGERED_SCOPE_CAPTURE_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define TSC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define TSC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define TSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tsc_pkg.sv -----
package tsc_pkg;

    localparam int BUFFER_DEPTH = 512;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
    localparam int RA_W         = 9;
    localparam int CMP_W        = (FILL_W > RA_W) ? FILL_W : RA_W;
    localparam int TICK_W       = 17;
    localparam int SAMPLE_W     = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EXTERNAL_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 3'd4;

    typedef enum logic [1:0] {
        SCH_UNKNOWN = 2'd0,
        SCH_LOW     = 2'd1,
        SCH_HIGH    = 2'd2
    } t_sch_state;

    typedef enum logic [1:0] {
        CAUSE_NONE      = 2'd0,
        CAUSE_NO_SOURCE = 2'd1,
        CAUSE_EDGE      = 2'd2,
        CAUSE_TIMEOUT   = 2'd3
    } t_cause;

    typedef struct packed {
        logic                external_mode;
        logic [15:0]         decimation;
        logic [15:0]         trigger_level;
        logic [14:0]         hysteresis;
        logic [15:0]         hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic                write_strobe;
        logic [RA_W-1:0]     write_index;
        logic                waiting;
        t_cause              rearm_cause;
    } t_ctl_res;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } t_wr_req;

endpackage

// ----- rtl/tsc_in_if.sv -----
interface tsc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_value;
    logic        sample_present;
    logic [15:0] trigger_value;
    logic        trigger_present;
    logic [8:0]  read_address;

    modport source (output valid, sample_value, sample_present, trigger_value,
                    trigger_present, read_address, input ready);
    modport sink   (input valid, sample_value, sample_present, trigger_value,
                    trigger_present, read_address, output ready);
endinterface

// ----- rtl/tsc_out_if.sv -----
interface tsc_out_if;
    logic        valid;
    logic        ready;
    logic        write_strobe;
    logic [8:0]  write_index;
    logic        waiting;
    logic [1:0]  rearm_cause;
    logic        signal_active;
    logic [15:0] read_data;

    modport source (output valid, write_strobe, write_index, waiting, rearm_cause,
                    signal_active, read_data, input ready);
    modport sink   (input valid, write_strobe, write_index, waiting, rearm_cause,
                    signal_active, read_data, output ready);
endinterface

// ----- rtl/tsc_ram.sv -----
module tsc_ram (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [tsc_pkg::RA_W-1:0]        i_rd_addr,
    input  tsc_pkg::t_wr_req                i_wr,
    output logic [tsc_pkg::SAMPLE_W-1:0]    o_rd_data
);
    import tsc_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [BUFFER_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_q;
    logic                r_rd_ok;
    logic [FILL_W-1:0]   r_hw;
    logic [FILL_W-1:0]   n_hw;
    logic [CMP_W-1:0]    ra_ext;
    logic [FILL_W-1:0]   wr_next;

    // Entries are only ever written in ascending order from zero, so all
    // entries below the high-water count have been written at least once.
    assign ra_ext  = CMP_W'(i_rd_addr);
    assign wr_next = FILL_W'(i_wr.addr) + FILL_W'(1);

    always_comb begin
        n_hw = r_hw;
        if (i_accept && i_wr.we && (wr_next > r_hw)) begin
            n_hw = wr_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw <= '0;
        end else begin
            r_hw <= n_hw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_q  <= r_mem[ra_ext[ADDR_W-1:0]];
            r_rd_ok <= (ra_ext < CMP_W'(BUFFER_DEPTH)) && (ra_ext < CMP_W'(r_hw));
        end
        if (i_accept && i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_q : '0;

endmodule

// ----- rtl/tsc_ctrl.sv -----
module tsc_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [tsc_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic [tsc_pkg::SAMPLE_W-1:0] i_trigger_value,
    input  logic                         i_trigger_present,
    input  tsc_pkg::t_cfg                i_cfg,
    output tsc_pkg::t_ctl_res            o_res,
    output tsc_pkg::t_wr_req             o_wr
);
    import tsc_pkg::*;

    `include "triggered_scope_capture_assert.svh"

    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(BUFFER_DEPTH);

    logic [FILL_W-1:0] r_fill, n_fill;
    logic [TICK_W-1:0] r_tick, n_tick;
    t_sch_state        r_sch, n_sch, sch_cur;

    logic [TICK_W-1:0] tick_inc;
    logic [CMP_W-1:0]  fill_ext;
    logic [16:0]       g17, lvl17, thr_lo;
    logic              lvl_hi, lvl_lo, trig_edge;

    assign fill_ext = CMP_W'(r_fill);
    assign tick_inc = r_tick + TICK_W'(1);
    assign g17      = i_cfg.external_mode ? {i_trigger_value[15], i_trigger_value}
                                          : {i_sample_value[15], i_sample_value};
    assign lvl17    = {i_cfg.trigger_level[15], i_cfg.trigger_level};
    assign thr_lo   = lvl17 - {2'b00, i_cfg.hysteresis};
    assign lvl_hi   = $signed(g17) >= $signed(lvl17);
    assign lvl_lo   = $signed(g17) <= $signed(thr_lo);

    always_comb begin
        n_fill    = r_fill;
        n_tick    = r_tick;
        n_sch     = r_sch;
        sch_cur   = r_sch;
        trig_edge = 1'b0;
        o_wr.we   = 1'b0;
        o_wr.addr = r_fill[ADDR_W-1:0];
        o_wr.data = i_sample_value;
        o_res.write_strobe = 1'b0;
        o_res.write_index  = '0;
        o_res.rearm_cause  = CAUSE_NONE;

        // Capture: keep one tick in decimation+1.
        if (r_fill != DEPTH_F) begin
            if (tick_inc > {1'b0, i_cfg.decimation}) begin
                n_tick             = '0;
                n_fill             = r_fill + FILL_W'(1);
                o_wr.we            = 1'b1;
                o_res.write_strobe = 1'b1;
                o_res.write_index  = fill_ext[RA_W-1:0];
            end else begin
                n_tick = tick_inc;
            end
        end

        // Wait for a re-arm event once the buffer is full.
        if (n_fill == DEPTH_F) begin
            if (i_cfg.external_mode && !i_trigger_present) begin
                o_res.rearm_cause = CAUSE_NO_SOURCE;
            end else begin
                // A fresh wait starts with the trigger state forgotten.
                sch_cur = (n_tick == '0) ? SCH_UNKNOWN : r_sch;
                n_tick  = n_tick + TICK_W'(1);
                n_sch   = sch_cur;
                unique case (sch_cur)
                    SCH_LOW: begin
                        if (lvl_hi) begin
                            n_sch     = SCH_HIGH;
                            trig_edge = 1'b1;
                        end
                    end
                    SCH_HIGH: begin
                        if (lvl_lo) begin
                            n_sch = SCH_LOW;
                        end
                    end
                    default: begin
                        if (lvl_hi) begin
                            n_sch = SCH_HIGH;
                        end else if (lvl_lo) begin
                            n_sch = SCH_LOW;
                        end
                    end
                endcase
                if (trig_edge) begin
                    o_res.rearm_cause = CAUSE_EDGE;
                end else if (n_tick >= {1'b0, i_cfg.hold_ticks}) begin
                    o_res.rearm_cause = CAUSE_TIMEOUT;
                end
            end
            if (o_res.rearm_cause != CAUSE_NONE) begin
                n_fill = '0;
                n_tick = '0;
            end
        end

        o_res.waiting = (n_fill == DEPTH_F);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_tick <= '0;
            r_sch  <= SCH_UNKNOWN;
        end else if (i_accept) begin
            r_fill <= n_fill;
            r_tick <= n_tick;
            r_sch  <= n_sch;
        end
    end

    `TSC_ASSERT_ALWAYS(a_fill_bound, r_fill <= DEPTH_F, "fill index beyond buffer depth")
    `TSC_ASSERT_SAME(a_no_store_full, o_wr.we, r_fill != DEPTH_F, "store while buffer full")
    `TSC_ASSERT_NEXT(a_rearm_clears, i_accept && (o_res.rearm_cause != CAUSE_NONE),
                     (r_fill == '0) && (r_tick == '0), "re-arm left counters set")
    `TSC_ASSERT_NEXT(a_wait_holds,
                     i_accept && (r_fill == DEPTH_F) && (o_res.rearm_cause == CAUSE_NONE),
                     r_fill == DEPTH_F, "left waiting without a re-arm")

endmodule

// ----- rtl/triggered_scope_capture.sv -----
// Results are registered, valid from the cycle after their request is accepted. Throughput:
// one request per cycle unless the output stalls; each request makes one read and at most one
// write of the simple dual-port capture memory; the control counters settle in the same cycle.
// Reset: synchronous, active low; it resets the counters, the trigger state and the
// configuration; the buffer is not swept, as a high-water count makes unwritten entries read 0.
module triggered_scope_capture (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tsc_in_if.sink                           i_in,
    tsc_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tsc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tsc_pkg::*;

    // Configuration registers. The user must write them only while the block is idle (the block
    // does not enforce it), so the control logic sees them as constants during a run of requests.
    t_cfg     r_cfg;

    // Output stage. A new request is taken whenever the stage is empty or its
    // result is being taken in the same cycle, so the block streams one request
    // per cycle while results are taken; a finished result left waiting stalls the input.
    logic     r_out_valid;
    logic     r_strobe;
    logic [RA_W-1:0] r_widx;
    logic     r_waiting;
    t_cause   r_cause;
    logic     r_active;

    logic     in_ready;
    logic     accept;
    t_ctl_res ctl_res;
    t_wr_req  wr_req;
    logic [SAMPLE_W-1:0] rd_data;

    assign in_ready   = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.external_mode <= 1'b0;
            r_cfg.decimation    <= 16'd3;
            r_cfg.trigger_level <= 16'd0;
            r_cfg.hysteresis    <= 15'd328;
            r_cfg.hold_ticks    <= 16'd4410;
        end else if (i_cfg_we) begin
            // Indices beyond the register list are ignored.
            unique case (i_cfg_index)
                CFG_EXTERNAL_MODE: r_cfg.external_mode <= i_cfg_data[0];
                CFG_DECIMATION:    r_cfg.decimation    <= i_cfg_data;
                CFG_TRIGGER_LEVEL: r_cfg.trigger_level <= i_cfg_data;
                CFG_HYSTERESIS:    r_cfg.hysteresis    <= i_cfg_data[14:0];
                CFG_HOLD_TICKS:    r_cfg.hold_ticks    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The controller works out the whole tick combinationally from the stored
    // counters; the memory write it asks for lands at the accepting edge.
    tsc_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_sample_value    (i_in.sample_value),
        .i_trigger_value   (i_in.trigger_value),
        .i_trigger_present (i_in.trigger_present),
        .i_cfg             (r_cfg),
        .o_res             (ctl_res),
        .o_wr              (wr_req)
    );

    // The readout is registered inside the memory and taken at the same edge as
    // the write, so it returns the entry as it stood before this tick's store.
    tsc_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rd_addr (i_in.read_address),
        .i_wr      (wr_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_strobe  <= ctl_res.write_strobe;
            r_widx    <= ctl_res.write_index;
            r_waiting <= ctl_res.waiting;
            r_cause   <= ctl_res.rearm_cause;
            r_active  <= i_in.sample_present;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.write_strobe  = r_strobe;
    assign o_out.write_index   = r_widx;
    assign o_out.waiting       = r_waiting;
    assign o_out.rearm_cause   = r_cause;
    assign o_out.signal_active = r_active;
    assign o_out.read_data     = rd_data;

endmodule
